### rtl/core/pat_pkg.sv
// Shared types and codes for the presence aging table.
package pat_pkg;

  localparam int unsigned ADDR_W    = 48;
  localparam int unsigned TIME_W    = 32;
  localparam int unsigned TIMEOUT_W = 31;
  localparam int unsigned LIVES_W   = 4;
  localparam int unsigned FUNC_W    = 2;
  localparam int unsigned CFG_IDX_W = 8;
  localparam int unsigned CFG_DAT_W = 32;

  localparam logic [FUNC_W-1:0] FUNC_SIGHT = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_TICK  = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_WATCH = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LIVES   = 8'd1;

  localparam logic [TIMEOUT_W-1:0] TIMEOUT_RST = 31'd10000;
  localparam logic [LIVES_W-1:0]   LIVES_RST   = 4'd3;

  typedef struct packed {
    logic [ADDR_W-1:0]  addr;
    logic [TIME_W-1:0]  seen;
    logic [LIVES_W-1:0] lives;
    logic               present;
  } entry_t;

  typedef struct packed {
    logic [ADDR_W-1:0] addr;
    logic              present;
    logic              is_new;
    logic              full;
  } result_t;

  typedef struct packed {
    logic [FUNC_W-1:0]    func;
    logic [ADDR_W-1:0]    addr;
    logic [TIME_W-1:0]    now;
    logic [TIMEOUT_W-1:0] timeout;
    logic [LIVES_W-1:0]   reload;
  } item_ctx_t;

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_SCAN  = 4'b0010,
    ST_FIN   = 4'b0100,
    ST_FLUSH = 4'b1000
  } state_e;

endpackage

### rtl/core/pat_cell.sv
// One table cell: holds an entry and takes its neighbour's entry on a shift.
module pat_cell (
  input  logic            clk_i,
  input  logic            shift_en_i,
  input  pat_pkg::entry_t shift_data_i,
  input  logic            wr_en_i,
  input  pat_pkg::entry_t wr_data_i,
  output pat_pkg::entry_t data_o
);
  import pat_pkg::*;

  entry_t entry_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      entry_q <= wr_data_i;
    end else if (shift_en_i) begin
      entry_q <= shift_data_i;
    end
  end

  assign data_o = entry_q;

endmodule

### rtl/core/pat_head.sv
// Update logic at the head of the ring: refresh or age the entry passing by.
module pat_head (
  input  pat_pkg::entry_t    entry_i,
  input  logic               valid_i,
  input  pat_pkg::item_ctx_t ctx_i,
  output pat_pkg::entry_t    entry_o,
  output logic               event_o,
  output logic               match_o
);
  import pat_pkg::*;

  logic [TIME_W-1:0] elapsed;
  logic              expired;
  logic [LIVES_W-1:0] lives_dec;

  assign elapsed   = ctx_i.now - entry_i.seen;
  assign expired   = elapsed > {1'b0, ctx_i.timeout};
  assign lives_dec = entry_i.lives - LIVES_W'(1);

  always_comb begin
    entry_o = entry_i;
    event_o = 1'b0;
    match_o = 1'b0;
    case (ctx_i.func)
      FUNC_SIGHT: begin
        if (valid_i && entry_i.addr == ctx_i.addr) begin
          entry_o.present = 1'b1;
          entry_o.seen    = ctx_i.now;
          entry_o.lives   = ctx_i.reload;
          event_o         = 1'b1;
          match_o         = 1'b1;
        end
      end
      FUNC_TICK: begin
        if (valid_i && entry_i.lives != '0 && expired) begin
          entry_o.lives = lives_dec;
          entry_o.seen  = ctx_i.now;
          if (lives_dec == '0) begin
            entry_o.present = 1'b0;
            event_o         = 1'b1;
          end
        end
      end
      default: begin
      end
    endcase
  end

endmodule

### rtl/core/presence_aging_table_core.sv
// Top level of the presence aging table: ring of cells, sequencer and output stage.
//
// Input beats arrive on the s_axis channel: tuser carries the function code
// (sighting, tick or watch), tdata the device address and the current time.
// Results leave on m_axis, one beat per event, tlast on the final event of an
// item. Registers (timeout, lives reload) are written on the cfg channel,
// which is always ready; write them only while the block is idle.
// The table is a ring of TABLE_DEPTH cells that rotates by one cell a cycle
// while an item is scanned, unless halted; the head cell passes through the
// update logic. A sighting or a tick scans every cell, then passes the finish
// and flush states; a watch or an unused code goes straight to finish and flush.
// The input reopens on the edge that leaves flush. s_axis_tready_o is high only
// while idle, even with a result still waiting; one item is worked at a time.
// Events wait one in a pending slot so that tlast can be set on the final
// one, then move to the output register. When the receiver stalls, the ring
// halts until the output register frees, so no event is lost.
// Reset clears the entry count, watch-only mode, registers to defaults and
// the control state; cell contents stay undefined and are never read unwritten.
module presence_aging_table_core #(
  parameter int unsigned TABLE_DEPTH = 32
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // tdata: address [47:0], now_ms [79:48]
  input  logic [79:0]                   s_axis_tdata_i,
  // tuser: func [1:0]
  input  logic [pat_pkg::FUNC_W-1:0]    s_axis_tuser_i,
  input  logic                          s_axis_tvalid_i,
  output logic                          s_axis_tready_o,
  // tdata: event_address [47:0]
  output logic [pat_pkg::ADDR_W-1:0]    m_axis_tdata_o,
  // tuser: present [0], is_new [1], table_full [2]
  output logic [2:0]                    m_axis_tuser_o,
  output logic                          m_axis_tlast_o,
  output logic                          m_axis_tvalid_o,
  input  logic                          m_axis_tready_i,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [pat_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [pat_pkg::CFG_DAT_W-1:0] cfg_data_i
);
  import pat_pkg::*;

  localparam int unsigned IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(TABLE_DEPTH + 1);

  // Registers and item context
  logic [TIMEOUT_W-1:0] timeout_q, timeout_d;
  logic [LIVES_W-1:0]   reload_q, reload_d;
  logic [FUNC_W-1:0]    func_q;
  logic [ADDR_W-1:0]    addr_q;
  logic [TIME_W-1:0]    now_q;

  state_e             state_q, state_d;
  logic [IDX_W-1:0]   idx_q, idx_d;
  logic [CNT_W-1:0]   count_q, count_d;
  logic               watch_q, watch_d;
  logic               found_q, found_d;

  logic               pend_v_q, pend_v_d;
  result_t            pend_q, pend_d;
  logic               out_v_q, out_v_d;
  result_t            out_q, out_d;
  logic               out_last_q, out_last_d;

  entry_t             cell_data [TABLE_DEPTH];
  entry_t             head_next;
  logic               head_event, head_match;
  item_ctx_t          ctx;

  logic               in_beat, cfg_beat, out_free, shift_en, ins_en;
  logic               fin_event, table_full;
  result_t            new_ev, fin_ev;
  entry_t             ins_data;

  assign in_beat   = s_axis_tvalid_i && s_axis_tready_o;
  assign cfg_beat  = cfg_valid_i && cfg_ready_o;
  assign out_free  = !out_v_q || m_axis_tready_i;
  assign table_full = count_q >= CNT_W'(TABLE_DEPTH);

  assign ctx.func    = func_q;
  assign ctx.addr    = addr_q;
  assign ctx.now     = now_q;
  assign ctx.timeout = timeout_q;
  assign ctx.reload  = reload_q;

  pat_head u_head (
    .entry_i (cell_data[0]),
    .valid_i (CNT_W'(idx_q) < count_q),
    .ctx_i   (ctx),
    .entry_o (head_next),
    .event_o (head_event),
    .match_o (head_match)
  );

  // Ring of cells: each takes its upper neighbour, the top takes the head result
  for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
    entry_t shift_in;
    if (i == TABLE_DEPTH - 1) begin : g_top
      assign shift_in = head_next;
    end else begin : g_mid
      assign shift_in = cell_data[i+1];
    end
    pat_cell u_cell (
      .clk_i        (clk_i),
      .shift_en_i   (shift_en),
      .shift_data_i (shift_in),
      .wr_en_i      (ins_en && count_q == CNT_W'(i)),
      .wr_data_i    (ins_data),
      .data_o       (cell_data[i])
    );
  end

  assign new_ev.addr    = cell_data[0].addr;
  assign new_ev.present = head_next.present;
  assign new_ev.is_new  = 1'b0;
  assign new_ev.full    = 1'b0;

  assign ins_data.addr    = addr_q;
  assign ins_data.seen    = now_q;
  assign ins_data.lives   = reload_q;
  assign ins_data.present = (func_q == FUNC_SIGHT);

  // Closing event of an item: insert of an unknown address, or a drop on a full table
  always_comb begin
    fin_event      = 1'b0;
    fin_ev.addr    = addr_q;
    fin_ev.present = 1'b0;
    fin_ev.is_new  = 1'b0;
    fin_ev.full    = 1'b0;
    case (func_q)
      FUNC_SIGHT: begin
        if (!found_q && !watch_q) begin
          fin_event      = 1'b1;
          fin_ev.present = !table_full;
          fin_ev.is_new  = !table_full;
          fin_ev.full    = table_full;
        end
      end
      FUNC_WATCH: begin
        if (table_full) begin
          fin_event   = 1'b1;
          fin_ev.full = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    state_d    = state_q;
    idx_d      = idx_q;
    count_d    = count_q;
    watch_d    = watch_q;
    found_d    = found_q;
    pend_v_d   = pend_v_q;
    pend_d     = pend_q;
    out_v_d    = out_v_q && !m_axis_tready_i;
    out_d      = out_q;
    out_last_d = out_last_q;
    shift_en   = 1'b0;
    ins_en     = 1'b0;
    timeout_d  = timeout_q;
    reload_d   = reload_q;

    if (cfg_beat) begin
      if (cfg_index_i == REG_TIMEOUT) begin
        timeout_d = cfg_data_i[TIMEOUT_W-1:0];
      end else if (cfg_index_i == REG_LIVES) begin
        reload_d = cfg_data_i[LIVES_W-1:0];
      end
    end

    case (state_q)
      ST_IDLE: begin
        if (in_beat) begin
          idx_d   = '0;
          found_d = 1'b0;
          if (s_axis_tuser_i == FUNC_SIGHT || s_axis_tuser_i == FUNC_TICK) begin
            state_d = ST_SCAN;
          end else begin
            state_d = ST_FIN;
          end
        end
      end
      ST_SCAN: begin
        // Halt the ring while a second event has nowhere to go
        if (!head_event || !pend_v_q || out_free) begin
          shift_en = 1'b1;
          if (head_match) begin
            found_d = 1'b1;
          end
          if (head_event) begin
            if (pend_v_q) begin
              out_v_d    = 1'b1;
              out_d      = pend_q;
              out_last_d = 1'b0;
            end
            pend_v_d = 1'b1;
            pend_d   = new_ev;
          end
          idx_d = idx_q + IDX_W'(1);
          if (idx_q == IDX_W'(TABLE_DEPTH - 1)) begin
            idx_d   = '0;
            state_d = ST_FIN;
          end
        end
      end
      ST_FIN: begin
        if (!fin_event || !pend_v_q || out_free) begin
          if (func_q == FUNC_WATCH) begin
            watch_d = 1'b1;
          end
          if (!table_full && (func_q == FUNC_WATCH ||
              (func_q == FUNC_SIGHT && !found_q && !watch_q))) begin
            ins_en  = 1'b1;
            count_d = count_q + CNT_W'(1);
          end
          if (fin_event) begin
            if (pend_v_q) begin
              out_v_d    = 1'b1;
              out_d      = pend_q;
              out_last_d = 1'b0;
            end
            pend_v_d = 1'b1;
            pend_d   = fin_ev;
          end
          state_d = ST_FLUSH;
        end
      end
      ST_FLUSH: begin
        // Release the held event with tlast
        if (!pend_v_q) begin
          state_d = ST_IDLE;
        end else if (out_free) begin
          out_v_d    = 1'b1;
          out_d      = pend_q;
          out_last_d = 1'b1;
          pend_v_d   = 1'b0;
          state_d    = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      idx_q     <= '0;
      count_q   <= '0;
      watch_q   <= 1'b0;
      found_q   <= 1'b0;
      pend_v_q  <= 1'b0;
      out_v_q   <= 1'b0;
      timeout_q <= TIMEOUT_RST;
      reload_q  <= LIVES_RST;
    end else begin
      state_q   <= state_d;
      idx_q     <= idx_d;
      count_q   <= count_d;
      watch_q   <= watch_d;
      found_q   <= found_d;
      pend_v_q  <= pend_v_d;
      out_v_q   <= out_v_d;
      timeout_q <= timeout_d;
      reload_q  <= reload_d;
    end
  end

  // Payload: no reset
  always_ff @(posedge clk_i) begin
    pend_q     <= pend_d;
    out_q      <= out_d;
    out_last_q <= out_last_d;
    if (in_beat) begin
      func_q <= s_axis_tuser_i;
      addr_q <= s_axis_tdata_i[ADDR_W-1:0];
      now_q  <= s_axis_tdata_i[ADDR_W+TIME_W-1:ADDR_W];
    end
  end

  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign cfg_ready_o     = 1'b1;
  assign m_axis_tvalid_o = out_v_q;
  assign m_axis_tdata_o  = out_q.addr;
  assign m_axis_tuser_o  = {out_q.full, out_q.is_new, out_q.present};
  assign m_axis_tlast_o  = out_last_q;

endmodule

### rtl/core/pat_checker.sv
// Port-level checks for the presence aging table, bound to the top level.
module pat_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid_i,
  input logic        s_axis_tready_o,
  input logic [47:0] m_axis_tdata_o,
  input logic [2:0]  m_axis_tuser_o,
  input logic        m_axis_tlast_o,
  input logic        m_axis_tvalid_o,
  input logic        m_axis_tready_i
);

  // A stalled result beat holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=>
      m_axis_tvalid_o && $stable(m_axis_tdata_o) && $stable(m_axis_tuser_o) &&
      $stable(m_axis_tlast_o))
    else $error("result beat changed while stalled");

  // One item at a time: input closes after an accepted beat
  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid_i && s_axis_tready_o |=> !s_axis_tready_o)
    else $error("input accepted while an item is in work");

  // A drop on a full table reports neither present nor new
  a_full_flags: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tuser_o[2] |-> !m_axis_tuser_o[0] && !m_axis_tuser_o[1])
    else $error("table_full with present or is_new set");

  // Insert and drop events close their item and new implies present
  a_new_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && (m_axis_tuser_o[1] || m_axis_tuser_o[2]) |->
      m_axis_tlast_o && (m_axis_tuser_o[0] || !m_axis_tuser_o[1]))
    else $error("insert or drop event not final");

endmodule

bind presence_aging_table_core pat_checker u_pat_checker (.*);

### tb/presence_aging_table_checker.sv
// Shadow table for the presence aging table core: predicts event beats and checks them.
`timescale 1ns / 1ps
module presence_aging_table_checker #(
  parameter int unsigned TABLE_DEPTH = 32
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic [79:0]                   s_tdata_i,
  input  logic [pat_pkg::FUNC_W-1:0]    s_tuser_i,
  input  logic                          s_tvalid_i,
  input  logic                          s_tready_i,
  input  logic [pat_pkg::ADDR_W-1:0]    m_tdata_i,
  input  logic [2:0]                    m_tuser_i,
  input  logic                          m_tlast_i,
  input  logic                          m_tvalid_i,
  input  logic                          m_tready_i,
  input  logic                          cfg_valid_i,
  input  logic                          cfg_ready_i,
  input  logic [pat_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [pat_pkg::CFG_DAT_W-1:0] cfg_data_i,
  output int unsigned                   fail_count_o,
  output int unsigned                   pending_o
);
  import pat_pkg::*;

  typedef struct packed {
    result_t res;
    logic    last;
  } event_beat_t;

  // entries are never removed, so index < fill_count is the valid set
  entry_t               shadow_tbl [TABLE_DEPTH];
  int                   fill_count;
  logic                 watch_mode;
  logic [TIMEOUT_W-1:0] timeout_r;
  logic [LIVES_W-1:0]   reload_r;
  event_beat_t          due_events_q [$];

  function automatic event_beat_t make_beat(input logic [ADDR_W-1:0] a, input logic p,
                                            input logic n, input logic f);
    event_beat_t b;
    b.res.addr    = a;
    b.res.present = p;
    b.res.is_new  = n;
    b.res.full    = f;
    b.last        = 1'b0;
    return b;
  endfunction

  function automatic bit take_free_entry(input logic [ADDR_W-1:0] a,
                                         input logic [TIME_W-1:0] t, input logic p);
    if (fill_count >= TABLE_DEPTH) return 1'b0;
    shadow_tbl[fill_count].addr    = a;
    shadow_tbl[fill_count].seen    = t;
    shadow_tbl[fill_count].lives   = reload_r;
    shadow_tbl[fill_count].present = p;
    fill_count++;
    return 1'b1;
  endfunction

  task automatic run_table_item(input logic [FUNC_W-1:0] func, input logic [ADDR_W-1:0] addr,
                                input logic [TIME_W-1:0] now);
    event_beat_t       batch [$];
    logic              matched;
    logic [TIME_W-1:0] elapsed;
    matched = 1'b0;
    case (func)
      FUNC_SIGHT: begin
        for (int i = 0; i < fill_count; i++) begin
          if (shadow_tbl[i].addr == addr) begin
            shadow_tbl[i].present = 1'b1;
            shadow_tbl[i].seen    = now;
            shadow_tbl[i].lives   = reload_r;
            batch.push_back(make_beat(addr, 1'b1, 1'b0, 1'b0));
            matched = 1'b1;
          end
        end
        if (!matched && !watch_mode) begin
          if (take_free_entry(addr, now, 1'b1))
            batch.push_back(make_beat(addr, 1'b1, 1'b1, 1'b0));
          else
            batch.push_back(make_beat(addr, 1'b0, 1'b0, 1'b1));
        end
      end
      FUNC_TICK: begin
        for (int i = 0; i < fill_count; i++) begin
          if (shadow_tbl[i].lives != '0) begin
            elapsed = now - shadow_tbl[i].seen;
            if (elapsed > {1'b0, timeout_r}) begin
              shadow_tbl[i].lives = shadow_tbl[i].lives - LIVES_W'(1);
              shadow_tbl[i].seen  = now;
              if (shadow_tbl[i].lives == '0) begin
                shadow_tbl[i].present = 1'b0;
                batch.push_back(make_beat(shadow_tbl[i].addr, 1'b0, 1'b0, 1'b0));
              end
            end
          end
        end
      end
      FUNC_WATCH: begin
        watch_mode = 1'b1;
        if (!take_free_entry(addr, now, 1'b0))
          batch.push_back(make_beat(addr, 1'b0, 1'b0, 1'b1));
      end
      default: ;
    endcase
    if (batch.size() > 0) batch[batch.size()-1].last = 1'b1;
    foreach (batch[k]) due_events_q.push_back(batch[k]);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    event_beat_t exp_b;
    if (!rst_ni) begin
      fill_count   = 0;
      watch_mode   = 1'b0;
      timeout_r    = TIMEOUT_RST;
      reload_r     = LIVES_RST;
      due_events_q.delete();
      fail_count_o = 0;
      pending_o    = 0;
    end else begin
      if (m_tvalid_i && m_tready_i) begin
        if (due_events_q.size() == 0) begin
          $display(
            "%0t: extra event beat: expected none, actual addr %h pres %b new %b full %b last %b",
            $time, m_tdata_i, m_tuser_i[0], m_tuser_i[1], m_tuser_i[2], m_tlast_i);
          fail_count_o++;
        end else begin
          exp_b = due_events_q.pop_front();
          if (exp_b.res.addr !== m_tdata_i || exp_b.res.present !== m_tuser_i[0] ||
              exp_b.res.is_new !== m_tuser_i[1] || exp_b.res.full !== m_tuser_i[2] ||
              exp_b.last !== m_tlast_i) begin
            $display("%0t: event beat mismatch: expected addr %h present %b new %b full %b last %b",
                     $time, exp_b.res.addr, exp_b.res.present, exp_b.res.is_new,
                     exp_b.res.full, exp_b.last);
            $display("%0t:                      actual   addr %h present %b new %b full %b last %b",
                     $time, m_tdata_i, m_tuser_i[0], m_tuser_i[1], m_tuser_i[2], m_tlast_i);
            fail_count_o++;
          end
        end
      end
      if (s_tvalid_i && s_tready_i) run_table_item(s_tuser_i, s_tdata_i[47:0], s_tdata_i[79:48]);
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          REG_TIMEOUT: timeout_r = cfg_data_i[TIMEOUT_W-1:0];
          REG_LIVES:   reload_r  = cfg_data_i[LIVES_W-1:0];
          default: ;
        endcase
      end
      pending_o = due_events_q.size();
    end
  end

endmodule

### tb/presence_aging_table_core_tb.sv
// Testbench top for the presence aging table core: stimulus, back-pressure and verdict.
`timescale 1ns / 1ps
module presence_aging_table_core_tb;
  import pat_pkg::*;

  localparam int unsigned TABLE_DEPTH     = 32;
  localparam int unsigned PHASES          = 7;
  localparam int unsigned ITEMS_PER_PHASE = 37;
  localparam int unsigned POOL_SIZE       = 48;
  // a full pass over the ring plus the output stage, with some margin
  localparam int unsigned SETTLE_CYCLES   = TABLE_DEPTH + 8;
  localparam int unsigned LONG_HOLD       = 300;
  localparam int unsigned WATCHDOG_LIMIT  = 4000;
  // the one function code the block ignores
  localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;

  logic                 clk       = 1'b0;
  logic                 rst_n     = 1'b0;
  logic [79:0]          s_tdata   = '0;
  logic [FUNC_W-1:0]    s_tuser   = FUNC_SIGHT;
  logic                 s_tvalid  = 1'b0;
  logic                 s_tready;
  logic [ADDR_W-1:0]    m_tdata;
  logic [2:0]           m_tuser;
  logic                 m_tlast;
  logic                 m_tvalid;
  logic                 m_tready  = 1'b0;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = REG_TIMEOUT;
  logic [CFG_DAT_W-1:0] cfg_data  = '0;

  int unsigned fail_count;
  int unsigned pending;
  int unsigned quiet_cycles = 0;

  // shared between the stimulus and the receiver process
  bit sender_idle_on = 1'b1;
  bit quiet_tail     = 1'b0;
  bit hold_request   = 1'b0;

  presence_aging_table_core #(
    .TABLE_DEPTH(TABLE_DEPTH)
  ) dut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .s_axis_tdata_i  (s_tdata),
    .s_axis_tuser_i  (s_tuser),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_tready),
    .m_axis_tdata_o  (m_tdata),
    .m_axis_tuser_o  (m_tuser),
    .m_axis_tlast_o  (m_tlast),
    .m_axis_tvalid_o (m_tvalid),
    .m_axis_tready_i (m_tready),
    .cfg_valid_i     (cfg_valid),
    .cfg_ready_o     (cfg_ready),
    .cfg_index_i     (cfg_index),
    .cfg_data_i      (cfg_data)
  );

  presence_aging_table_checker #(
    .TABLE_DEPTH(TABLE_DEPTH)
  ) checker_i (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .s_tdata_i    (s_tdata),
    .s_tuser_i    (s_tuser),
    .s_tvalid_i   (s_tvalid),
    .s_tready_i   (s_tready),
    .m_tdata_i    (m_tdata),
    .m_tuser_i    (m_tuser),
    .m_tlast_i    (m_tlast),
    .m_tvalid_i   (m_tvalid),
    .m_tready_i   (m_tready),
    .cfg_valid_i  (cfg_valid),
    .cfg_ready_i  (cfg_ready),
    .cfg_index_i  (cfg_index),
    .cfg_data_i   (cfg_data),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  always #10 clk = ~clk;

  // Hold reset from the start, release on a falling edge, never assert again.
  initial begin
    repeat (7) @(negedge clk);
    rst_n <= 1'b1;
  end

  // Watchdog: end the run once no channel has moved a beat for too long.
  always @(posedge clk) begin
    if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  // Receiver: stall in random bursts, hold off for a long stretch when asked,
  // and stay ready throughout the closing phase.
  initial begin : receiver
    int unsigned stall_left;
    int unsigned hold_left;
    logic        ready_next;
    stall_left = 0;
    hold_left  = 0;
    forever begin
      @(negedge clk);
      if (hold_request) begin
        hold_left    = LONG_HOLD;
        hold_request = 1'b0;
      end
      if (hold_left != 0) begin
        hold_left--;
        ready_next = 1'b0;
      end else if (quiet_tail) begin
        ready_next = 1'b1;
      end else if (stall_left != 0) begin
        stall_left--;
        ready_next = 1'b0;
      end else if ($urandom_range(0, 4) == 0) begin
        // stall this cycle and draw how many more to stall
        stall_left = $urandom_range(0, 7);
        ready_next = 1'b0;
      end else begin
        ready_next = 1'b1;
      end
      m_tready <= ready_next;
    end
  end

  function automatic logic [ADDR_W-1:0] random_address();
    logic [63:0] wide;
    wide = {$urandom, $urandom};
    return wide[ADDR_W-1:0];
  endfunction

  // Offer one input beat and return on the falling edge after it is taken.
  // Called on a falling edge; tvalid stays high into the next beat unless a gap is drawn.
  task automatic send_item(input logic [FUNC_W-1:0] f, input logic [ADDR_W-1:0] a,
                           input logic [TIME_W-1:0] t);
    int unsigned gap;
    if (sender_idle_on && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 8);
      s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tuser  <= f;
    s_tdata  <= {t, a};
    s_tvalid <= 1'b1;
    do @(posedge clk); while (!s_tready);
    @(negedge clk);
  endtask

  // Wait until every predicted event has arrived, then let the ring finish any
  // item that raises no event at all.
  task automatic settle();
    while (pending != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // Write both registers back to back, then drop the write channel.
  task automatic set_config(input logic [TIMEOUT_W-1:0] timeout_v,
                            input logic [LIVES_W-1:0] lives_v);
    cfg_index <= REG_TIMEOUT;
    cfg_data  <= {1'b0, timeout_v};
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_index <= REG_LIVES;
    cfg_data  <= {{(CFG_DAT_W-LIVES_W){1'b0}}, lives_v};
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  initial begin : stimulus
    logic [ADDR_W-1:0]    addr_pool [POOL_SIZE];
    logic [ADDR_W-1:0]    addr;
    logic [FUNC_W-1:0]    func;
    logic [TIME_W-1:0]    clock_ms;
    logic [TIMEOUT_W-1:0] timeout_cur;
    logic [LIVES_W-1:0]   lives_cur;
    bit                   full_first;
    int unsigned          pre_watch_span;
    int unsigned          span;
    int unsigned          pick;
    int unsigned          roll;

    // Build the address pool: the two extremes, two addresses that each differ
    // from a third in a single bit, and random addresses for the rest.
    addr_pool[0] = '0;
    addr_pool[1] = '1;
    for (int i = 2; i < POOL_SIZE; i++) addr_pool[i] = random_address();
    addr_pool[3] = addr_pool[2] ^ 48'h1;
    addr_pool[4] = addr_pool[2] ^ 48'h8000_0000_0000;

    // The table never empties and watch-only mode never clears, so one run can
    // reach either a sighting dropped on a full table (fill with sightings first)
    // or watched entries actually landing (keep sightings to a small set). Let
    // the seed pick which.
    full_first     = ($urandom_range(0, 1) == 1);
    pre_watch_span = full_first ? POOL_SIZE : 18;

    @(posedge rst_n);
    @(negedge clk);

    // Directed part at the reset register values: 10000 ms timeout, 3 lives.
    send_item(FUNC_SIGHT, addr_pool[0], 32'd0);
    send_item(FUNC_SIGHT, addr_pool[1], 32'hFFFF_FFFF);
    send_item(FUNC_SIGHT, addr_pool[0], 32'd5);
    send_item(FUNC_SIGHT, addr_pool[2], 32'd5);
    send_item(FUNC_SIGHT, addr_pool[3], 32'd6);
    // elapsed exactly at the timeout for the first entry: it must hold
    send_item(FUNC_TICK, random_address(), 32'd10005);
    send_item(FUNC_UNUSED, random_address(), $urandom);
    send_item(FUNC_TICK, random_address(), 32'd10006);
    // three long gaps run every entry out of lives, then leave them at zero
    for (int k = 1; k <= 3; k++) send_item(FUNC_TICK, random_address(), 32'd10006 + k * 20002);
    send_item(FUNC_SIGHT, addr_pool[1], 32'd70020);
    send_item(FUNC_TICK, random_address(), 32'd70030);
    send_item(FUNC_SIGHT, addr_pool[4], 32'd70031);
    send_item(FUNC_SIGHT, addr_pool[4], 32'd70032);
    clock_ms = 32'd70032;

    for (int ph = 0; ph < PHASES; ph++) begin
      s_tvalid <= 1'b0;
      settle();
      case (ph)
        0: begin timeout_cur = '0;            lives_cur = 4'd1;  end
        1: begin timeout_cur = 31'd1;         lives_cur = 4'd15; end
        2: begin
          timeout_cur = TIMEOUT_W'($urandom_range(100, 5000));
          lives_cur   = LIVES_W'($urandom_range(1, 4));
        end
        3: begin timeout_cur = 31'h7FFF_FFFF; lives_cur = 4'd0;  end
        4: begin timeout_cur = TIMEOUT_W'($urandom_range(0, 3000)); lives_cur = 4'd2; end
        5: begin
          timeout_cur = TIMEOUT_W'($urandom);
          lives_cur   = LIVES_W'($urandom_range(0, 15));
        end
        default: begin timeout_cur = 31'd500; lives_cur = 4'd3; end
      endcase
      set_config(timeout_cur, lives_cur);
      // starve the output early on so the ring halts and the input stalls
      if (ph == 1) hold_request = 1'b1;
      if (ph == PHASES - 1) begin
        sender_idle_on = 1'b0;
        quiet_tail     = 1'b1;
      end

      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        // advance the clock around the timeout, with an occasional jump anywhere
        if ($urandom_range(0, 7) == 0) begin
          clock_ms = $urandom;
        end else begin
          span     = (timeout_cur < 4000) ? 2 * timeout_cur + 3 : 8000;
          clock_ms = clock_ms + $urandom_range(0, span);
        end
        pick = $urandom_range(0, (ph < 3) ? pre_watch_span - 1 : POOL_SIZE - 1);
        addr = addr_pool[pick];
        if (ph >= 3 && $urandom_range(0, 9) == 0) addr = random_address();
        roll = $urandom_range(0, 99);
        if (roll < 4)                func = FUNC_UNUSED;
        else if (ph == 3 && roll < 42) func = FUNC_WATCH;
        else if (ph > 3 && roll < 8)   func = FUNC_WATCH;
        else if (roll < 70)            func = FUNC_SIGHT;
        else                           func = FUNC_TICK;
        send_item(func, addr, clock_ms);
      end
    end

    s_tvalid <= 1'b0;
    settle();
    if (fail_count == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

endmodule
